@@ rtl/cmdfr_pkg.sv @@
package cmdfr_pkg;

    // Frame bytes
    localparam logic [7:0] BYTE_OPEN    = 8'h7B;
    localparam logic [7:0] BYTE_G       = 8'h47;
    localparam logic [7:0] BYTE_T       = 8'h54;
    localparam logic [7:0] BYTE_VER0    = 8'h5A;
    localparam logic [7:0] BYTE_VER1    = 8'h58;
    localparam logic [7:0] BYTE_CMD     = 8'h00;
    localparam logic [7:0] CKSUM_BASE   = 8'hFF;
    localparam logic [7:0] BYTE_E       = 8'h45;
    localparam logic [7:0] BYTE_N       = 8'h4E;
    localparam logic [7:0] BYTE_D       = 8'h44;
    localparam logic [7:0] BYTE_CLOSE   = 8'h7D;

    typedef logic [3:0] step_t;

    // Position of each byte within a frame
    localparam step_t STEP_OPEN  = 4'd0;
    localparam step_t STEP_G     = 4'd1;
    localparam step_t STEP_T     = 4'd2;
    localparam step_t STEP_ADDR  = 4'd3;
    localparam step_t STEP_VER0  = 4'd4;
    localparam step_t STEP_VER1  = 4'd5;
    localparam step_t STEP_CMD   = 4'd6;
    localparam step_t STEP_LEN   = 4'd7;
    localparam step_t STEP_DATA  = 4'd8;
    localparam step_t STEP_CKSUM = 4'd9;
    localparam step_t STEP_E     = 4'd10;
    localparam step_t STEP_N     = 4'd11;
    localparam step_t STEP_D     = 4'd12;
    localparam step_t STEP_CLOSE = 4'd13;

    typedef struct packed {
        logic  valid;
        step_t step;
    } step_sel_t;

    typedef struct packed {
        logic       first;
        logic       last;
        logic       has_data;
        logic [7:0] dest_addr;
        logic [7:0] payload_len;
        logic [7:0] data_byte;
    } item_t;

    // Byte handed to the output register
    typedef struct packed {
        logic       valid;
        logic [7:0] data;
        logic       frame_end;
    } emit_t;

    typedef struct packed {
        logic  busy;
        logic  in_frame;
        step_t step;
    } ctrl_status_t;

    function automatic step_sel_t first_step(input logic first, input logic has_data,
                                             input logic last, input logic in_frame);
        step_sel_t sel;
        sel.valid = 1'b1;
        sel.step  = STEP_OPEN;
        if (first) begin
            sel.step = STEP_OPEN;
        end else if (!in_frame) begin
            sel.valid = 1'b0;
        end else if (has_data) begin
            sel.step = STEP_DATA;
        end else if (last) begin
            sel.step = STEP_CKSUM;
        end else begin
            sel.valid = 1'b0;
        end
        return sel;
    endfunction

    function automatic step_sel_t next_step(input step_t step, input logic has_data,
                                            input logic last);
        step_sel_t sel;
        sel.valid = 1'b1;
        sel.step  = step + 4'd1;
        unique case (step)
            STEP_LEN: begin
                if (has_data) begin
                    sel.step = STEP_DATA;
                end else begin
                    sel.valid = last;
                    sel.step  = STEP_CKSUM;
                end
            end
            STEP_DATA: begin
                sel.valid = last;
                sel.step  = STEP_CKSUM;
            end
            STEP_CLOSE: begin
                sel.valid = 1'b0;
                sel.step  = STEP_OPEN;
            end
            default: begin
                sel.step = step + 4'd1;
            end
        endcase
        return sel;
    endfunction

endpackage

@@ rtl/cmdfr_ctrl.sv @@
module cmdfr_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   req_valid,
    output logic                   req_ready,
    input  cmdfr_pkg::item_t       req_item,
    input  logic                   out_ready,
    output cmdfr_pkg::emit_t       emit,
    output cmdfr_pkg::ctrl_status_t status
);

    logic                 busy_reg, busy_next;
    cmdfr_pkg::item_t     item_reg, item_next;
    cmdfr_pkg::step_t     step_reg, step_next;
    logic                 in_frame_reg, in_frame_next;
    logic [7:0]           sum_reg, sum_next;

    logic                 fire;
    logic                 done;
    logic                 accept;
    logic [7:0]           cur_byte;
    cmdfr_pkg::step_sel_t nxt;
    cmdfr_pkg::step_sel_t start;

    assign fire      = busy_reg && out_ready;
    assign nxt       = cmdfr_pkg::next_step(step_reg, item_reg.has_data, item_reg.last);
    assign done      = fire && !nxt.valid;
    assign req_ready = !busy_reg || done;
    assign accept    = req_valid && req_ready;

    always_comb begin
        unique case (step_reg)
            cmdfr_pkg::STEP_OPEN:  cur_byte = cmdfr_pkg::BYTE_OPEN;
            cmdfr_pkg::STEP_G:     cur_byte = cmdfr_pkg::BYTE_G;
            cmdfr_pkg::STEP_T:     cur_byte = cmdfr_pkg::BYTE_T;
            cmdfr_pkg::STEP_ADDR:  cur_byte = item_reg.dest_addr;
            cmdfr_pkg::STEP_VER0:  cur_byte = cmdfr_pkg::BYTE_VER0;
            cmdfr_pkg::STEP_VER1:  cur_byte = cmdfr_pkg::BYTE_VER1;
            cmdfr_pkg::STEP_CMD:   cur_byte = cmdfr_pkg::BYTE_CMD;
            cmdfr_pkg::STEP_LEN:   cur_byte = item_reg.payload_len;
            cmdfr_pkg::STEP_DATA:  cur_byte = item_reg.data_byte;
            cmdfr_pkg::STEP_CKSUM: cur_byte = cmdfr_pkg::CKSUM_BASE - sum_reg;
            cmdfr_pkg::STEP_E:     cur_byte = cmdfr_pkg::BYTE_E;
            cmdfr_pkg::STEP_N:     cur_byte = cmdfr_pkg::BYTE_N;
            cmdfr_pkg::STEP_D:     cur_byte = cmdfr_pkg::BYTE_D;
            cmdfr_pkg::STEP_CLOSE: cur_byte = cmdfr_pkg::BYTE_CLOSE;
            default:               cur_byte = cmdfr_pkg::BYTE_CLOSE;
        endcase
    end

    assign emit.valid     = fire;
    assign emit.data      = cur_byte;
    assign emit.frame_end = (step_reg == cmdfr_pkg::STEP_CLOSE);

    // Checksum runs from the address byte; the address restarts it
    always_comb begin
        sum_next      = sum_reg;
        in_frame_next = in_frame_reg;
        if (fire) begin
            if (step_reg == cmdfr_pkg::STEP_ADDR) begin
                sum_next = item_reg.dest_addr;
            end else if (step_reg == cmdfr_pkg::STEP_VER0 || step_reg == cmdfr_pkg::STEP_VER1
                         || step_reg == cmdfr_pkg::STEP_CMD || step_reg == cmdfr_pkg::STEP_LEN
                         || step_reg == cmdfr_pkg::STEP_DATA) begin
                sum_next = sum_reg + cur_byte;
            end
            if (step_reg == cmdfr_pkg::STEP_OPEN) begin
                in_frame_next = 1'b1;
            end else if (step_reg == cmdfr_pkg::STEP_CLOSE) begin
                in_frame_next = 1'b0;
            end
        end
    end

    // A request that yields no bytes is taken and dropped at once
    assign start = cmdfr_pkg::first_step(req_item.first, req_item.has_data, req_item.last,
                                         in_frame_next);

    always_comb begin
        busy_next = busy_reg;
        item_next = item_reg;
        step_next = step_reg;
        if (accept) begin
            busy_next = start.valid;
            item_next = req_item;
            step_next = start.step;
        end else if (done) begin
            busy_next = 1'b0;
        end else if (fire) begin
            step_next = nxt.step;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg     <= 1'b0;
            in_frame_reg <= 1'b0;
            sum_reg      <= 8'd0;
            step_reg     <= cmdfr_pkg::STEP_OPEN;
        end else begin
            busy_reg     <= busy_next;
            in_frame_reg <= in_frame_next;
            sum_reg      <= sum_next;
            step_reg     <= step_next;
        end
        item_reg <= item_next;
    end

    assign status.busy     = busy_reg;
    assign status.in_frame = in_frame_reg;
    assign status.step     = step_reg;

endmodule

@@ rtl/cmdfr_out.sv @@
module cmdfr_out (
    input  logic             aclk,
    input  logic             aresetn,
    input  cmdfr_pkg::emit_t emit,
    output logic             out_ready,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [7:0]       m_tdata,
    output logic             m_tlast
);

    logic       valid_reg, valid_next;
    logic [7:0] data_reg, data_next;
    logic       last_reg, last_next;

    assign out_ready = !valid_reg || m_tready;

    always_comb begin
        valid_next = valid_reg;
        data_next  = data_reg;
        last_next  = last_reg;
        if (out_ready) begin
            valid_next = emit.valid;
            data_next  = emit.data;
            last_next  = emit.frame_end;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        data_reg <= data_next;
        last_reg <= last_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tlast  = last_reg;

endmodule

@@ rtl/checksummed_command_framer.sv @@
// Write command framer: each request carries at most one payload byte and
// leaves one byte per cycle on the master side while m_tready is high. A
// first request emits the header '{' 'G' 'T' addr 0x5A 0x58 0x00 len before
// its byte, a last request appends the checksum (0xFF minus the byte sum
// from addr on) and 'E' 'N' 'D' '}'. A request yields one byte as a plain
// payload byte, nine as a first byte, six as a last byte, and thirteen or
// fourteen as a single-request frame. Plain payload requests stream back to
// back. A non-first request outside an open frame, or one with no data, no
// first and no last, is taken and yields nothing. A first request inside an
// open frame drops that frame without trailer and starts a new one.
module checksummed_command_framer (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // dest_addr[7:0], payload_len[15:8], data_byte[23:16]
    input  logic [1:0]  s_tuser,   // first[0], has_data[1]
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // out_byte[7:0]
    output logic        m_tlast
);

    cmdfr_pkg::item_t        req_item;
    cmdfr_pkg::emit_t        emit;
    cmdfr_pkg::ctrl_status_t status;
    logic                    out_ready;

    assign req_item.first       = s_tuser[0];
    assign req_item.has_data    = s_tuser[1];
    assign req_item.last        = s_tlast;
    assign req_item.dest_addr   = s_tdata[7:0];
    assign req_item.payload_len = s_tdata[15:8];
    assign req_item.data_byte   = s_tdata[23:16];

    cmdfr_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .req_valid (s_tvalid),
        .req_ready (s_tready),
        .req_item  (req_item),
        .out_ready (out_ready),
        .emit      (emit),
        .status    (status)
    );

    cmdfr_out u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .emit      (emit),
        .out_ready (out_ready),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    a_end_is_close: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tdata == cmdfr_pkg::BYTE_CLOSE)
        else $error("frame end flagged on a byte other than the closing brace");

    a_body_in_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        status.busy && status.step != cmdfr_pkg::STEP_OPEN |-> status.in_frame)
        else $error("frame body byte pending with no open frame");

    a_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        emit.valid |-> out_ready)
        else $error("byte emitted while output register is full");

    a_close_ends_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        emit.valid && emit.frame_end |=> !status.in_frame)
        else $error("frame still open after closing byte");

endmodule

@@ tb/tb_checksummed_command_framer.sv @@
module tb_checksummed_command_framer;

    localparam int unsigned IDLE_LIMIT      = 2000;
    localparam int unsigned HOLD_OFF_CYCLES = 300;
    localparam int unsigned RANDOM_ITEMS    = 105;
    localparam int unsigned DRAIN_CYCLES    = 20;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       frame_end;
    } frame_byte_t;

    // Predicts the framed byte stream and checks what the block sends back.
    class frame_scoreboard;
        logic [7:0]  byte_sum   = 8'h00;
        bit          open_frame = 1'b0;
        frame_byte_t expected_bytes[$];
        int unsigned error_count = 0;

        function void push_byte(input logic [7:0] value, input logic is_end);
            frame_byte_t fb;
            fb.out_byte  = value;
            fb.frame_end = is_end;
            expected_bytes.push_back(fb);
        endfunction

        function void note_request(input logic first, input logic last, input logic has_data,
                                   input logic [7:0] addr, input logic [7:0] len,
                                   input logic [7:0] data);
            // drop requests that arrive outside an open frame
            if (!first && !open_frame) return;
            if (first) begin
                push_byte(cmdfr_pkg::BYTE_OPEN, 1'b0);
                push_byte(cmdfr_pkg::BYTE_G, 1'b0);
                push_byte(cmdfr_pkg::BYTE_T, 1'b0);
                push_byte(addr, 1'b0);
                push_byte(cmdfr_pkg::BYTE_VER0, 1'b0);
                push_byte(cmdfr_pkg::BYTE_VER1, 1'b0);
                push_byte(cmdfr_pkg::BYTE_CMD, 1'b0);
                push_byte(len, 1'b0);
                byte_sum   = addr + cmdfr_pkg::BYTE_VER0 + cmdfr_pkg::BYTE_VER1
                             + cmdfr_pkg::BYTE_CMD + len;
                open_frame = 1'b1;
            end
            if (has_data) begin
                push_byte(data, 1'b0);
                byte_sum = byte_sum + data;
            end
            if (last) begin
                push_byte(cmdfr_pkg::CKSUM_BASE - byte_sum, 1'b0);
                push_byte(cmdfr_pkg::BYTE_E, 1'b0);
                push_byte(cmdfr_pkg::BYTE_N, 1'b0);
                push_byte(cmdfr_pkg::BYTE_D, 1'b0);
                push_byte(cmdfr_pkg::BYTE_CLOSE, 1'b1);
                byte_sum   = 8'h00;
                open_frame = 1'b0;
            end
        endfunction

        function void check_byte(input logic [7:0] value, input logic is_end);
            frame_byte_t want;
            if (expected_bytes.size() == 0) begin
                $display("%0t: unexpected byte: expected none, actual out_byte %02h frame_end %b",
                         $time, value, is_end);
                error_count++;
                return;
            end
            want = expected_bytes.pop_front();
            if (value !== want.out_byte) begin
                $display("%0t: out_byte mismatch: expected %02h, actual %02h",
                         $time, want.out_byte, value);
                error_count++;
            end
            if (is_end !== want.frame_end) begin
                $display("%0t: frame_end mismatch: expected %b, actual %b",
                         $time, want.frame_end, is_end);
                error_count++;
            end
        endfunction

        function int unsigned pending();
            return expected_bytes.size();
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;   // dest_addr[7:0], payload_len[15:8], data_byte[23:16]
    logic [1:0]  s_tuser;   // first[0], has_data[1]
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;   // out_byte[7:0]
    logic        m_tlast;

    frame_scoreboard sb = new;
    bit              hold_off_request = 1'b0;
    int unsigned     idle_cycles = 0;

    checksummed_command_framer dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic bit coin();
        return 1'($urandom_range(0, 1));
    endfunction

    // Mostly short gaps, now and then a long one.
    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 45) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send_request(input bit first, input bit last, input bit has_data,
                                input logic [7:0] addr, input logic [7:0] len,
                                input logic [7:0] data, input bit no_gap);
        int unsigned gap;
        gap = no_gap ? 0 : pick_gap();
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {data, len, addr};
        s_tuser  <= {has_data, first};
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
    endtask

    // Well-formed frame with random content; an abandoned one never sees its last request.
    task automatic random_frame(input int unsigned n_items, input bit abandon, input bit fast);
        for (int unsigned i = 0; i < n_items; i++) begin
            send_request(i == 0, (i == n_items - 1) && !abandon, $urandom_range(0, 9) != 0,
                         rand_byte(), rand_byte(), rand_byte(), fast);
        end
    endtask

    // Result side: take bytes in bursts between random stalls.
    initial begin
        int unsigned burst;
        int unsigned stall;
        m_tready <= 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            m_tready <= 1'b1;
            burst = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 8);
            repeat (burst) @(posedge aclk);
            if (hold_off_request) begin
                hold_off_request = 1'b0;
                stall = HOLD_OFF_CYCLES;
            end else begin
                stall = pick_gap();
            end
            if (stall != 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
        end
    end

    // Note requests before checking bytes so a same-edge pair stays ordered.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready)
                sb.note_request(s_tuser[0], s_tlast, s_tuser[1],
                                s_tdata[7:0], s_tdata[15:8], s_tdata[23:16]);
            if (m_tvalid && m_tready)
                sb.check_byte(m_tdata, m_tlast);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("%0t: no handshake for %0d cycles", $time, idle_cycles);
                $display("tb_checksummed_command_framer NOT OK");
                $finish;
            end
        end
    end

    initial begin
        int unsigned random_items;
        int unsigned roll;
        int unsigned n_items;
        bit          pressure_done;
        random_items  = 0;
        pressure_done = 1'b0;
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= '0;
        s_tlast  <= 1'b0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // stray request before any frame is open
        send_request(1'b0, 1'b1, 1'b1, 8'hFF, 8'hFF, 8'hFF, 1'b0);
        // empty frame, then single-byte frame at the upper extremes
        send_request(1'b1, 1'b1, 1'b0, 8'h00, 8'h00, 8'h00, 1'b0);
        send_request(1'b1, 1'b1, 1'b1, 8'hFF, 8'hFF, 8'hFF, 1'b1);
        // mid-frame request with no data yields nothing
        send_request(1'b1, 1'b0, 1'b1, 8'h12, 8'h03, 8'h00, 1'b0);
        send_request(1'b0, 1'b0, 1'b1, 8'hEE, 8'hDD, 8'h80, 1'b1);
        send_request(1'b0, 1'b0, 1'b0, 8'h11, 8'h22, 8'h99, 1'b0);
        send_request(1'b0, 1'b1, 1'b1, 8'h00, 8'h00, 8'h7F, 1'b0);
        // last request without data
        send_request(1'b1, 1'b0, 1'b1, 8'h80, 8'h01, 8'h01, 1'b1);
        send_request(1'b0, 1'b1, 1'b0, 8'h00, 8'h00, 8'h00, 1'b1);
        // restart inside an open frame
        send_request(1'b1, 1'b0, 1'b1, 8'hA5, 8'h02, 8'h55, 1'b0);
        send_request(1'b0, 1'b0, 1'b1, 8'h5A, 8'hA5, 8'hAA, 1'b0);
        send_request(1'b1, 1'b0, 1'b1, 8'h5A, 8'hFF, 8'h33, 1'b1);
        send_request(1'b0, 1'b1, 1'b1, 8'h01, 8'h01, 8'hCC, 1'b0);
        // header only on the first request
        send_request(1'b1, 1'b0, 1'b0, 8'h7F, 8'h01, 8'hFF, 1'b0);
        send_request(1'b0, 1'b1, 1'b1, 8'hFF, 8'hFF, 8'h01, 1'b0);
        send_request(1'b0, 1'b0, 1'b1, 8'h00, 8'h00, 8'h42, 1'b0);
        // length byte disagrees with the payload count
        send_request(1'b1, 1'b0, 1'b1, 8'h3C, 8'd200, 8'hFE, 1'b1);
        send_request(1'b0, 1'b1, 1'b1, 8'hC3, 8'h00, 8'hFD, 1'b1);

        while (random_items < RANDOM_ITEMS) begin
            roll = $urandom_range(0, 99);
            if (roll < 8) begin
                send_request(1'b0, coin(), coin(), rand_byte(), rand_byte(), rand_byte(), 1'b0);
                random_items++;
            end else if (roll < 14) begin
                send_request(1'b1, 1'b1, coin(), rand_byte(), rand_byte(), rand_byte(), 1'b0);
                random_items++;
            end else begin
                n_items = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24)
                                                      : $urandom_range(1, 6);
                random_frame(n_items, $urandom_range(0, 19) == 0, $urandom_range(0, 3) == 0);
                random_items += n_items;
            end
            // hold the result side off while requests keep coming
            if (!pressure_done && random_items >= 40) begin
                hold_off_request = 1'b1;
                pressure_done    = 1'b1;
            end
        end
        s_tvalid <= 1'b0;

        while (sb.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.error_count == 0 && sb.pending() == 0) begin
            $display("tb_checksummed_command_framer OK");
        end else begin
            $display("tb_checksummed_command_framer NOT OK");
        end
        $finish;
    end

endmodule
